// ----- rtl/cpdm_pkg.sv -----
// types, constants and the control program of the clock prescale divider mux
`default_nettype none

package cpdm_pkg;

  // request operation codes
  typedef enum logic [1:0] {
    OP_RECALC     = 2'd0,
    OP_ROUND      = 2'd1,
    OP_SET_RATE   = 2'd2,
    OP_SET_PARENT = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] source_rate;
    logic [31:0] target_rate;
    logic [7:0]  parent_index;
  } request_t;

  typedef struct packed {
    logic [31:0] rate_out;
    logic        error;
    logic [1:0]  mux_select;
    logic [1:0]  prescale_shift;
    logic [4:0]  divider_field;
  } result_t;

  localparam int unsigned DIV_WIDTH     = 32;
  localparam int unsigned DIV_CNT_WIDTH = $clog2(DIV_WIDTH);
  localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST_STEP = DIV_CNT_WIDTH'(DIV_WIDTH - 1);

  localparam logic [31:0] DIVISOR_LIMIT = 32'd32;
  localparam logic [1:0]  SHIFT_LIMIT   = 2'd3;

  // datapath micro-operations
  typedef enum logic [3:0] {
    UOP_LOAD_RECALC,
    UOP_LOAD_CEIL,
    UOP_LOAD_ROUND,
    UOP_DIV_STEP,
    UOP_ZERO_CHECK,
    UOP_TAKE_RATE,
    UOP_TAKE_CEIL,
    UOP_TAKE_EXACT,
    UOP_TRAIL_ZEROS,
    UOP_RAISE,
    UOP_CHECK_SET,
    UOP_SET_PARENT,
    UOP_FINISH
  } uop_t;

  // jump conditions: taken goes to target, otherwise to the next step
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_DIV_MORE,
    COND_RAISE,
    COND_ZERO,
    COND_REM_NZ,
    COND_HOLD
  } cond_t;

  typedef logic [4:0] upc_t;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    upc_t  target;
  } ctrl_word_t;

  // sequencer to datapath
  typedef struct packed {
    logic run;
    uop_t uop;
  } dp_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic div_more;
    logic raise_ok;
    logic zero_in;
    logic rem_nz;
  } dp_status_t;

  // program entry points
  localparam upc_t A_RECALC     = 5'd0;
  localparam upc_t A_ROUND      = 5'd3;
  localparam upc_t A_SET_RATE   = 5'd12;
  localparam upc_t A_SET_PARENT = 5'd18;
  localparam upc_t A_FINISH     = 5'd19;

  function automatic upc_t entry_point(input logic [1:0] op);
    upc_t a;
    unique case (op)
      OP_RECALC:   a = A_RECALC;
      OP_ROUND:    a = A_ROUND;
      OP_SET_RATE: a = A_SET_RATE;
      default:     a = A_SET_PARENT;
    endcase
    return a;
  endfunction

  // control store
  function automatic ctrl_word_t ucode_rom(input upc_t pc);
    ctrl_word_t w;
    unique case (pc)
      // recalc: (parent >> shift) / (divider + 1)
      5'd0:  w = '{UOP_LOAD_RECALC, COND_NEXT,     5'd0};
      5'd1:  w = '{UOP_DIV_STEP,    COND_DIV_MORE, 5'd1};
      5'd2:  w = '{UOP_TAKE_RATE,   COND_ALWAYS,   A_FINISH};
      // round
      5'd3:  w = '{UOP_ZERO_CHECK,  COND_ZERO,     A_FINISH};
      5'd4:  w = '{UOP_LOAD_CEIL,   COND_NEXT,     5'd0};
      5'd5:  w = '{UOP_DIV_STEP,    COND_DIV_MORE, 5'd5};
      5'd6:  w = '{UOP_TAKE_CEIL,   COND_NEXT,     5'd0};
      5'd7:  w = '{UOP_TRAIL_ZEROS, COND_NEXT,     5'd0};
      5'd8:  w = '{UOP_RAISE,       COND_RAISE,    5'd8};
      5'd9:  w = '{UOP_LOAD_ROUND,  COND_NEXT,     5'd0};
      5'd10: w = '{UOP_DIV_STEP,    COND_DIV_MORE, 5'd10};
      5'd11: w = '{UOP_TAKE_RATE,   COND_ALWAYS,   A_FINISH};
      // set rate
      5'd12: w = '{UOP_ZERO_CHECK,  COND_ZERO,     A_FINISH};
      5'd13: w = '{UOP_LOAD_CEIL,   COND_NEXT,     5'd0};
      5'd14: w = '{UOP_DIV_STEP,    COND_DIV_MORE, 5'd14};
      5'd15: w = '{UOP_TAKE_EXACT,  COND_REM_NZ,   A_FINISH};
      5'd16: w = '{UOP_TRAIL_ZEROS, COND_NEXT,     5'd0};
      5'd17: w = '{UOP_CHECK_SET,   COND_ALWAYS,   A_FINISH};
      // set parent
      5'd18: w = '{UOP_SET_PARENT,  COND_ALWAYS,   A_FINISH};
      // hand the result over, wait while the output register is full
      default: w = '{UOP_FINISH,    COND_HOLD,     A_FINISH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/clock_prescale_divider_mux.sv -----
// Clock control block with a parent mux select, a power-of-two prescaler and a
// five-bit divider. Each request runs a short microprogram on a shared datapath
// whose restoring divider yields one quotient bit per cycle. Round runs two
// divisions plus up to three prescale raises; set parent, and round or set
// rate with a zero rate, do not use the divider. One request is worked on at
// a time; a new one is taken as soon as the previous result sits in the output
// register, even if that result has not yet been taken.
`default_nettype none

module clock_prescale_divider_mux
  import cpdm_pkg::*;
#(
  parameter int MUX_INPUTS = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     request_valid,
  output logic          request_ready,
  input  wire request_t request,
  output logic          result_valid,
  input  wire logic     result_ready,
  output result_t       result
);

  logic       start;
  logic       busy;
  logic       hold;
  logic       load_out;
  dp_ctrl_t   ctrl;
  dp_status_t status;
  result_t    rsp;

  // request handshake
  assign request_ready = !busy;
  assign start         = request_valid && request_ready;
  assign hold          = result_valid && !result_ready;
  assign load_out      = ctrl.run && (ctrl.uop == UOP_FINISH) && !hold;

  cpdm_sequencer u_sequencer (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (request.operation),
    .status    (status),
    .hold      (hold),
    .busy      (busy),
    .ctrl      (ctrl)
  );

  cpdm_datapath #(
    .MUX_INPUTS (MUX_INPUTS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (request),
    .ctrl   (ctrl),
    .status (status),
    .rsp    (rsp)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result <= rsp;
    end
  end

`ifndef NO_ASSERTIONS
  a_error_zero_rate: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.error |-> result.rate_out == '0)
    else $error("rejected request reports a nonzero rate");

  a_mux_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> {30'd0, result.mux_select} < 32'(MUX_INPUTS))
    else $error("mux select beyond the parent count");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start |=> !request_ready)
    else $error("request taken without running its program");

  a_result_from_program: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(busy))
    else $error("result appeared without a finished program");
`endif

endmodule

`default_nettype wire

// ----- rtl/cpdm_divider.sv -----
// restoring divider, one quotient bit per cycle in which step is high
`default_nettype none

module cpdm_divider
  import cpdm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire logic        step,
  input  wire logic [31:0] numerator,
  input  wire logic [31:0] denominator,
  output logic [31:0]      quotient,
  output logic [31:0]      remainder,
  output logic             more
);

  logic [31:0]              den;
  logic [DIV_CNT_WIDTH-1:0] cnt;
  logic [32:0]              rem_shift;
  logic                     fits;

  // trial subtraction
  assign rem_shift = {remainder, quotient[31]};
  assign fits      = rem_shift >= {1'b0, den};
  assign more      = cnt != DIV_LAST_STEP;

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + 1'b1;
    end
  end

  // partial remainder and quotient
  always_ff @(posedge clk) begin
    if (load) begin
      quotient  <= numerator;
      remainder <= '0;
      den       <= denominator;
    end else if (step) begin
      quotient <= {quotient[30:0], fits};
      if (fits) begin
        remainder <= 32'(rem_shift - {1'b0, den});
      end else begin
        remainder <= rem_shift[31:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cpdm_datapath.sv -----
// datapath: request latch, clock control fields, working registers and divider
`default_nettype none

module cpdm_datapath
  import cpdm_pkg::*;
#(
  parameter int MUX_INPUTS = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire request_t req,
  input  wire dp_ctrl_t ctrl,
  output dp_status_t    status,
  output result_t       rsp
);

  request_t    req_q;
  logic [31:0] rate;
  logic        err;
  logic [31:0] d;
  logic [1:0]  s;
  logic [1:0]  mux_field;
  logic [1:0]  shift_field;
  logic [4:0]  divide_field;

  logic        div_load;
  logic        div_step;
  logic [31:0] div_num;
  logic [31:0] div_den;
  logic [31:0] quotient;
  logic [31:0] remainder;
  logic        div_more;
  logic [1:0]  tz;
  logic        index_ok;
  logic        set_ok;

  // divider operand selection
  always_comb begin
    div_load = 1'b0;
    div_num  = req_q.source_rate;
    div_den  = req_q.target_rate;
    if (ctrl.run) begin
      case (ctrl.uop)
        UOP_LOAD_RECALC: begin
          div_load = 1'b1;
          div_num  = req_q.source_rate >> shift_field;
          div_den  = {27'd0, divide_field} + 32'd1;
        end
        UOP_LOAD_CEIL: begin
          div_load = 1'b1;
        end
        UOP_LOAD_ROUND: begin
          div_load = 1'b1;
          div_num  = req_q.source_rate >> s;
          div_den  = d;
        end
        default: ;
      endcase
    end
  end

  assign div_step = ctrl.run && (ctrl.uop == UOP_DIV_STEP);

  cpdm_divider u_divider (
    .clk         (clk),
    .rst         (rst),
    .load        (div_load),
    .step        (div_step),
    .numerator   (div_num),
    .denominator (div_den),
    .quotient    (quotient),
    .remainder   (remainder),
    .more        (div_more)
  );

  // trailing zeros of the divisor, at most three
  always_comb begin
    if (d[0]) begin
      tz = 2'd0;
    end else if (d[1]) begin
      tz = 2'd1;
    end else if (d[2]) begin
      tz = 2'd2;
    end else begin
      tz = SHIFT_LIMIT;
    end
  end

  assign index_ok = {24'd0, req_q.parent_index} < 32'(MUX_INPUTS);
  assign set_ok   = d <= DIVISOR_LIMIT;

  // status for the sequencer
  assign status.div_more = div_more;
  assign status.raise_ok = (d > DIVISOR_LIMIT) && (s != SHIFT_LIMIT);
  assign status.zero_in  = (req_q.source_rate == '0) || (req_q.target_rate == '0);
  assign status.rem_nz   = remainder != '0;

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      req_q <= req;
      rate  <= '0;
      err   <= 1'b0;
    end else if (ctrl.run) begin
      case (ctrl.uop)
        UOP_ZERO_CHECK:  err <= status.zero_in;
        UOP_TAKE_RATE:   rate <= quotient;
        UOP_TAKE_CEIL:   d <= quotient + {31'd0, status.rem_nz};
        UOP_TAKE_EXACT: begin
          d   <= quotient;
          err <= status.rem_nz;
        end
        UOP_TRAIL_ZEROS: begin
          s <= tz;
          d <= d >> tz;
        end
        UOP_RAISE: begin
          if (status.raise_ok) begin
            s <= s + 2'd1;
            d <= d >> 1;
          end
        end
        UOP_CHECK_SET: begin
          // an exact ratio gives back the requested rate
          if (set_ok) begin
            rate <= req_q.target_rate;
          end else begin
            err <= 1'b1;
          end
        end
        UOP_SET_PARENT:  err <= !index_ok;
        default: ;
      endcase
    end
  end

  // clock control fields
  always_ff @(posedge clk) begin
    if (rst) begin
      mux_field    <= '0;
      shift_field  <= '0;
      divide_field <= '0;
    end else if (ctrl.run) begin
      if (ctrl.uop == UOP_CHECK_SET && set_ok) begin
        shift_field  <= s;
        divide_field <= d[4:0] - 5'd1;
      end
      if (ctrl.uop == UOP_SET_PARENT && index_ok) begin
        mux_field <= req_q.parent_index[1:0];
      end
    end
  end

  assign rsp.rate_out       = rate;
  assign rsp.error          = err;
  assign rsp.mux_select     = mux_field;
  assign rsp.prescale_shift = shift_field;
  assign rsp.divider_field  = divide_field;

endmodule

`default_nettype wire

// ----- rtl/cpdm_sequencer.sv -----
// micro-sequencer: step counter, control store and jump logic
`default_nettype none

module cpdm_sequencer
  import cpdm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [1:0] operation,
  input  wire dp_status_t status,
  input  wire logic       hold,
  output logic            busy,
  output dp_ctrl_t        ctrl
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t     state;
  upc_t       pc;
  ctrl_word_t word;
  logic       taken;

  assign word = ucode_rom(pc);

  // jump condition
  always_comb begin
    unique case (word.cond)
      COND_NEXT:     taken = 1'b0;
      COND_ALWAYS:   taken = 1'b1;
      COND_DIV_MORE: taken = status.div_more;
      COND_RAISE:    taken = status.raise_ok;
      COND_ZERO:     taken = status.zero_in;
      COND_REM_NZ:   taken = status.rem_nz;
      COND_HOLD:     taken = hold;
      default:       taken = 1'b0;
    endcase
  end

  assign busy     = state == S_RUN;
  assign ctrl.run = busy;
  assign ctrl.uop = word.uop;

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= A_RECALC;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
            pc    <= entry_point(operation);
          end
        end
        S_RUN: begin
          if (word.uop == UOP_FINISH && !hold) begin
            state <= S_IDLE;
          end else if (taken) begin
            pc <= word.target;
          end else begin
            pc <= pc + 5'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
